// ===== rtl/core/hbridge_ramp_with_reverse_coast_macros.svh =====
// Assertion macros for the H-bridge speed ramp.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef HBRIDGE_RAMP_WITH_REVERSE_COAST_MACROS_SVH
`define HBRIDGE_RAMP_WITH_REVERSE_COAST_MACROS_SVH

`ifndef SYNTHESIS
`define HRRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrrc: same-cycle check failed");
`define HRRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrrc: next-cycle check failed");
`else
`define HRRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define HRRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/hrrc_pkg.sv =====
// Types, codes and constants for the H-bridge speed ramp.
// Used by hrrc_ramp, hrrc_result and the top level; no dependencies.
package hrrc_pkg;

  localparam int FULL_PCT  = 100;
  localparam int FULL_DUTY = 255;

  localparam logic [15:0] UP_MS_RESET    = 16'd20;
  localparam logic [15:0] DOWN_MS_RESET  = 16'd50;
  localparam logic [15:0] COAST_MS_RESET = 16'd2000;

  typedef logic signed [7:0] level_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_BRAKE = 2'd2,
    REQ_COAST = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_UP_MS    = 2'd0,
    CFG_DOWN_MS  = 2'd1,
    CFG_COAST_MS = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] up_ms;
    logic [15:0] down_ms;
    logic [15:0] coast_ms;
  } cfg_t;

  typedef struct packed {
    level_t level;
    logic   enable;
    logic   active;
  } ramp_status_t;

  // true when the next one-percent step from lvl toward gl shrinks |lvl|
  function automatic logic toward_zero(level_t lvl, level_t gl);
    toward_zero = (lvl > 8'sd0 && gl < lvl) || (lvl < 8'sd0 && gl > lvl);
  endfunction

  // pct*255/100, divide by 100 as multiply by 5243 and shift by 19
  function automatic logic [7:0] duty_of(logic [6:0] pct);
    logic [14:0] prod;
    logic [27:0] scaled;
    prod   = 15'(pct) * 15'(FULL_DUTY);
    scaled = 28'(prod) * 28'd5243;
    if (pct == 7'd0) begin
      duty_of = 8'd0;
    end else if (pct >= 7'(FULL_PCT)) begin
      duty_of = 8'(FULL_DUTY);
    end else begin
      duty_of = scaled[26:19];
    end
  endfunction

endpackage

// ===== rtl/core/hrrc_ramp.sv =====
// Ramp state and its single-pass update for one event.
// Depends on hrrc_pkg and hbridge_ramp_with_reverse_coast_macros.svh.
`include "hbridge_ramp_with_reverse_coast_macros.svh"

module hrrc_ramp (
  input  logic                  clk,
  input  logic                  rst,
  input  hrrc_pkg::cfg_t        cfg,
  input  logic                  step,
  input  hrrc_pkg::req_t        req,
  input  hrrc_pkg::level_t      target,
  output hrrc_pkg::ramp_status_t status
);
  import hrrc_pkg::*;

  level_t      level, level_next;
  level_t      goal, goal_next;
  logic        reversing, reversing_next;
  logic        in_coast, in_coast_next;
  logic        active, active_next;
  logic [15:0] wait_left, wait_left_next;
  logic        enable, enable_next;

  level_t level_stepped;
  level_t target_clamped;

  always_comb begin
    if (level < goal) begin
      level_stepped = level + 8'sd1;
    end else if (level > goal) begin
      level_stepped = level - 8'sd1;
    end else begin
      level_stepped = level;
    end
    if (target > 8'sd100) begin
      target_clamped = 8'sd100;
    end else if (target < -8'sd100) begin
      target_clamped = -8'sd100;
    end else begin
      target_clamped = target;
    end
  end

  always_comb begin
    level_next     = level;
    goal_next      = goal;
    reversing_next = reversing;
    in_coast_next  = in_coast;
    active_next    = active;
    wait_left_next = wait_left;
    enable_next    = enable;
    case (req)
      REQ_TICK: begin
        if (active) begin
          if (wait_left <= 16'd1) begin
            wait_left_next = '0;
            if (in_coast) begin
              in_coast_next = 1'b0;
              enable_next   = 1'b1;
              if (level != goal) begin
                wait_left_next = toward_zero(level, goal) ? cfg.down_ms : cfg.up_ms;
              end else begin
                active_next = 1'b0;
              end
            end else begin
              level_next = level_stepped;
              if (level_stepped == 8'sd0 && goal != 8'sd0 && reversing) begin
                reversing_next = 1'b0;
                in_coast_next  = 1'b1;
                enable_next    = 1'b0;
                wait_left_next = cfg.coast_ms;
              end else if (level_stepped == goal) begin
                active_next = 1'b0;
              end else begin
                wait_left_next = toward_zero(level_stepped, goal) ? cfg.down_ms
                                                                  : cfg.up_ms;
              end
            end
          end else begin
            wait_left_next = wait_left - 16'd1;
          end
        end
      end
      REQ_SET: begin
        goal_next      = target_clamped;
        reversing_next = (level > 8'sd0 && target_clamped < 8'sd0) ||
                         (level < 8'sd0 && target_clamped > 8'sd0);
        if (level != target_clamped && !active) begin
          active_next    = 1'b1;
          wait_left_next = toward_zero(level, target_clamped) ? cfg.down_ms : cfg.up_ms;
        end
      end
      REQ_BRAKE, REQ_COAST: begin
        level_next     = '0;
        goal_next      = '0;
        reversing_next = 1'b0;
        in_coast_next  = 1'b0;
        active_next    = 1'b0;
        wait_left_next = '0;
        enable_next    = (req == REQ_BRAKE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      goal      <= '0;
      reversing <= 1'b0;
      in_coast  <= 1'b0;
      active    <= 1'b0;
      wait_left <= '0;
      enable    <= 1'b1;
    end else if (step) begin
      level     <= level_next;
      goal      <= goal_next;
      reversing <= reversing_next;
      in_coast  <= in_coast_next;
      active    <= active_next;
      wait_left <= wait_left_next;
      enable    <= enable_next;
    end
  end

  assign status = '{level: level_next, enable: enable_next, active: active_next};

  `HRRC_ASSERT_IMP(a_level_range, clk, rst, 1'b1, level <= 8'sd100 && level >= -8'sd100)
  `HRRC_ASSERT_IMP(a_coast_at_zero, clk, rst, in_coast, level == 8'sd0 && !enable && active)
  `HRRC_ASSERT_NEXT(a_stop_clears, clk, rst, step && (req == REQ_BRAKE || req == REQ_COAST),
                    !active && level == 8'sd0 && goal == 8'sd0)

endmodule

// ===== rtl/core/hrrc_result.sv =====
// Result register: scales the level to PWM duties and holds the output beat.
// Depends on hrrc_pkg and hbridge_ramp_with_reverse_coast_macros.svh.
`include "hbridge_ramp_with_reverse_coast_macros.svh"

module hrrc_result (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  hrrc_pkg::ramp_status_t status,
  output logic                   advance,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] fwd_duty, [15:8] rev_duty, [16] driver_enable,
  // [24:17] present_level, [25] ramping, [31:26] zero
  output logic [31:0]            m_tdata
);
  import hrrc_pkg::*;

  logic [7:0] fwd_duty, rev_duty;
  logic       driver_enable, ramping;
  level_t     present_level;
  level_t     level_neg;

  assign advance   = !m_tvalid || m_tready;
  assign level_neg = -status.level;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      fwd_duty      <= (status.level > 8'sd0) ? duty_of(status.level[6:0]) : 8'd0;
      rev_duty      <= (status.level < 8'sd0) ? duty_of(level_neg[6:0]) : 8'd0;
      driver_enable <= status.enable;
      present_level <= status.level;
      ramping       <= status.active;
    end
  end

  assign m_tdata = {6'd0, ramping, present_level, driver_enable, rev_duty, fwd_duty};

  `HRRC_ASSERT_IMP(a_one_direction, clk, rst, m_tvalid, fwd_duty == 8'd0 || rev_duty == 8'd0)
  `HRRC_ASSERT_IMP(a_duty_sign, clk, rst, m_tvalid && fwd_duty != 8'd0, present_level > 8'sd0)

endmodule

// ===== rtl/core/hbridge_ramp_with_reverse_coast.sv =====
// Top level of the H-bridge speed ramp: event register, ramp core, result register.
// Depends on hrrc_pkg, hrrc_ramp and hrrc_result.
//
// One event (tick, set target, brake or coast) is taken per clock and gives exactly one
// result beat. An event beat is held in an input register, the ramp state is updated from
// it in a single combinational pass and the result register is loaded, so each result
// passes through both registers. The rate is one event per cycle, limited only by the
// output side: the input stalls only while the result register is full and not taken.
// Configuration writes are always accepted and are meant for an idle block.
module hbridge_ramp_with_reverse_coast (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] target_pct
  input  logic [7:0]  s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] fwd_duty, [15:8] rev_duty, [16] driver_enable,
  // [24:17] present_level, [25] ramping, [31:26] zero
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hrrc_pkg::*;

  cfg_t         cfg;
  logic         item_valid;
  req_t         item_req;
  level_t       item_target;
  logic         advance;
  logic         step;
  ramp_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_ms    <= UP_MS_RESET;
      cfg.down_ms  <= DOWN_MS_RESET;
      cfg.coast_ms <= COAST_MS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UP_MS:    cfg.up_ms    <= cfg_data;
        CFG_DOWN_MS:  cfg.down_ms  <= cfg_data;
        CFG_COAST_MS: cfg.coast_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !item_valid || advance;
  assign step     = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_req    <= req_t'(s_tuser);
      item_target <= s_tdata;
    end
  end

  hrrc_ramp u_ramp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .req    (item_req),
    .target (item_target),
    .status (status)
  );

  hrrc_result u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (item_valid),
    .status   (status),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for hbridge_ramp_with_reverse_coast: stream driver, result monitor and
// an event-level predictor of the signed speed ramp, over several delay settings.
// Depends on hrrc_pkg and the RTL top level only.
module tb_top;
  import hrrc_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int LIMIT        = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 6;

  typedef struct {
    req_t   req;
    level_t pct;
  } event_t;

  typedef struct {
    logic [7:0] fwd;
    logic [7:0] rev;
    logic       en;
    level_t     lvl;
    logic       ramping;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  event_t event_q[$];
  drive_t duty_q[$];
  int     errors = 0;
  logic   in_sent = 1'b0;
  logic   out_sent = 1'b0;
  logic   tx_fast = 1'b0;
  logic   rx_fast = 1'b0;
  int     tx_gap = 0;
  int     rx_wait = 0;
  int     rx_hold = 0;
  int     rx_hold_req = 0;
  int     rx_hold_seen = 0;

  // predicted ramp state
  logic [15:0] up_cfg, down_cfg, coast_cfg;
  level_t      lvl, goal;
  logic        reversing, coasting, busy, en_lvl;
  logic [15:0] wait_cnt;

  hbridge_ramp_with_reverse_coast DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [7:0] duty(int p);
    if (p <= 0) return 8'd0;
    if (p >= FULL_PCT) return 8'(FULL_DUTY);
    return 8'((p * FULL_DUTY) / FULL_PCT);
  endfunction

  function automatic int idle_draw();
    return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic level_t rand_target();
    if ($urandom_range(0, 3) == 0) return level_t'($urandom_range(0, 255));
    return level_t'(int'($urandom_range(0, 200)) - 100);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic schedule_step();
    int nxt;
    nxt = (lvl < goal) ? int'(lvl) + 1 : int'(lvl) - 1;
    wait_cnt = (mag(nxt) < mag(int'(lvl))) ? down_cfg : up_cfg;
  endtask

  task automatic halt(logic en);
    busy      = 1'b0;
    lvl       = '0;
    goal      = '0;
    reversing = 1'b0;
    coasting  = 1'b0;
    wait_cnt  = '0;
    en_lvl    = en;
  endtask

  task automatic ramp_event(input event_t ev, output drive_t r);
    int t;
    case (ev.req)
      REQ_TICK: begin
        if (busy) begin
          if (wait_cnt <= 16'd1) begin
            wait_cnt = '0;
            if (coasting) begin
              coasting = 1'b0;
              en_lvl   = 1'b1;
              if (lvl != goal) schedule_step();
              else busy = 1'b0;
            end else begin
              if (lvl < goal) lvl++;
              else if (lvl > goal) lvl--;
              // reached zero on a reversal: drop the enables for the coast time
              if (lvl == 0 && goal != 0 && reversing) begin
                reversing = 1'b0;
                coasting  = 1'b1;
                en_lvl    = 1'b0;
                wait_cnt  = coast_cfg;
              end else if (lvl == goal) begin
                busy = 1'b0;
              end else begin
                schedule_step();
              end
            end
          end else begin
            wait_cnt--;
          end
        end
      end
      REQ_SET: begin
        t = int'(ev.pct);
        if (t > FULL_PCT) t = FULL_PCT;
        if (t < -FULL_PCT) t = -FULL_PCT;
        goal      = level_t'(t);
        reversing = (lvl > 0 && t < 0) || (lvl < 0 && t > 0);
        if (lvl != goal && !busy) begin
          busy = 1'b1;
          schedule_step();
        end
      end
      REQ_BRAKE: halt(1'b1);
      default:   halt(1'b0);
    endcase
    r.fwd     = duty(int'(lvl));
    r.rev     = duty(-int'(lvl));
    r.en      = en_lvl;
    r.lvl     = lvl;
    r.ramping = busy;
  endtask

  // predictor and monitor
  always @(posedge clk) begin : track
    event_t ev;
    drive_t want, got;
    if (rst) begin
      up_cfg    = UP_MS_RESET;
      down_cfg  = DOWN_MS_RESET;
      coast_cfg = COAST_MS_RESET;
      halt(1'b1);
      duty_q.delete();
      in_sent  = 1'b0;
      out_sent = 1'b0;
    end else begin
      in_sent  = s_tvalid && s_tready;
      out_sent = m_tvalid && m_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_UP_MS:    up_cfg    = cfg_data;
          CFG_DOWN_MS:  down_cfg  = cfg_data;
          CFG_COAST_MS: coast_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_sent) begin
        ev.req = req_t'(s_tuser);
        ev.pct = level_t'(s_tdata);
        ramp_event(ev, want);
        duty_q.push_back(want);
      end
      if (out_sent) begin
        got.fwd     = m_tdata[7:0];
        got.rev     = m_tdata[15:8];
        got.en      = m_tdata[16];
        got.lvl     = level_t'(m_tdata[24:17]);
        got.ramping = m_tdata[25];
        if (duty_q.size() == 0) begin
          $error("result beat with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = duty_q.pop_front();
          check_field("fwd_duty", int'(want.fwd), int'(got.fwd));
          check_field("rev_duty", int'(want.rev), int'(got.rev));
          check_field("driver_enable", int'(want.en), int'(got.en));
          check_field("present_level", int'(want.lvl), int'(got.lvl));
          check_field("ramping", int'(want.ramping), int'(got.ramping));
        end
      end
    end
  end

  // event driver
  always @(negedge clk) begin : feed
    event_t ev;
    logic   nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && in_sent) nv = 1'b0;
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (event_q.size() > 0) begin
          ev = event_q.pop_front();
          s_tuser <= ev.req;
          s_tdata <= ev.pct;
          nv = 1'b1;
          tx_gap = tx_fast ? 0 : idle_draw();
        end
      end
      s_tvalid <= nv;
    end
  end

  // result sink
  always @(negedge clk) begin : drain
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold = LONG_HOLD;
      end
      if (out_sent) rx_wait = rx_fast ? 0 : idle_draw();
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_event(req_t r, level_t p);
    event_q.push_back('{r, p});
  endtask

  task automatic push_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) push_event(REQ_TICK, level_t'($urandom_range(0, 255)));
    else if (r < 93) push_event(REQ_SET, rand_target());
    else if (r < 97) push_event(REQ_BRAKE, level_t'($urandom_range(0, 255)));
    else push_event(REQ_COAST, level_t'($urandom_range(0, 255)));
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (event_q.size() != 0 || s_tvalid || duty_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < LIMIT; cyc++) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stim
    int ph, n, k;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset delays: first step away from zero lands on the 20th tick
    push_event(REQ_SET, 8'sd1);
    repeat (20) push_event(REQ_TICK, 8'sd0);
    wait_idle();

    // zero up delay acts as one tick
    write_cfg(CFG_UP_MS, 16'd0);
    write_cfg(CFG_DOWN_MS, 16'd1);
    write_cfg(CFG_COAST_MS, 16'd2);
    @(posedge clk);
    push_event(REQ_SET, -8'sd128);       // clamped, reversal from +1
    push_event(REQ_TICK, 8'sd0);         // to zero, coast starts
    push_event(REQ_TICK, 8'sd0);
    push_event(REQ_TICK, 8'sd0);         // coast ends
    push_event(REQ_TICK, 8'sd0);
    push_event(REQ_SET, 8'sd127);        // clamped, reversal from -1
    push_event(REQ_TICK, 8'sd0);
    push_event(REQ_COAST, 8'sd0);
    push_event(REQ_SET, 8'sd50);         // enables stay low after coast
    push_event(REQ_TICK, 8'sd0);
    push_event(REQ_TICK, -8'sd1);        // pct ignored on tick
    push_event(REQ_BRAKE, 8'sd77);
    wait_idle();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_UP_MS, 16'd1);
          write_cfg(CFG_DOWN_MS, 16'd1);
          write_cfg(CFG_COAST_MS, 16'd1);
        end
        1: begin
          write_cfg(CFG_UP_MS, 16'd0);
          write_cfg(CFG_DOWN_MS, 16'd0);
          write_cfg(CFG_COAST_MS, 16'd0);
        end
        2: begin
          write_cfg(CFG_UP_MS, 16'hFFFF);
          write_cfg(CFG_DOWN_MS, 16'hFFFF);
          write_cfg(CFG_COAST_MS, 16'hFFFF);
        end
        default: begin
          write_cfg(CFG_UP_MS, 16'($urandom_range(0, 3)));
          write_cfg(CFG_DOWN_MS, 16'($urandom_range(0, 4)));
          write_cfg(CFG_COAST_MS, 16'($urandom_range(0, 8)));
        end
      endcase
      tx_fast = (ph == 4) || ($urandom_range(0, 3) == 0);
      rx_fast = (ph != 4) && ($urandom_range(0, 3) == 0);
      @(posedge clk);
      if (ph == 1) begin
        // full forward, partial ramp down on reversal, then full reverse
        push_event(REQ_SET, 8'sd127);
        repeat (100) push_event(REQ_TICK, 8'sd0);
        push_event(REQ_SET, -8'sd128);
        repeat (10) push_event(REQ_TICK, 8'sd0);
        push_event(REQ_BRAKE, 8'sd0);
        push_event(REQ_SET, -8'sd128);
        repeat (100) push_event(REQ_TICK, 8'sd0);
      end else begin
        n = 0;
        while (n < 20) begin
          push_event(REQ_SET, rand_target());
          n++;
          k = $urandom_range(1, 20);
          repeat (k) begin
            push_random();
            n++;
          end
        end
        if (ph == 2) push_event(REQ_BRAKE, 8'sd0);
      end
      if (ph == 4) rx_hold_req++;
      wait_idle();
    end

    if (duty_q.size() != 0) begin
      $error("%0d results never arrived", duty_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
